// ===== rtl/core/rqht_pkg.sv =====
// ----------------------------------------------------------------------------
// rqht_pkg
// Types and codes shared by the read quality histogram table modules.
// ----------------------------------------------------------------------------
package rqht_pkg;

    // Command codes on the input side
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_QREP  = 2'd2;
    localparam logic [1:0] CMD_LREP  = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_ADD_ACK   = 2'd0;
    localparam logic [1:0] KIND_CLEAR_ACK = 2'd1;
    localparam logic [1:0] KIND_QREP      = 2'd2;
    localparam logic [1:0] KIND_LWORD     = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  read_group;
        logic        second_mate;
        logic [5:0]  quality;
        logic [9:0]  fragment_length;
        logic [15:0] position;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        error;
        logic [31:0] total_count;
        logic [15:0] max_position;
        logic [63:0] used_mask;
        logic [3:0]  word_index;
        logic        last;
    } out_item_t;

    // Classified item as it waits in the queue
    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  read_group;
        logic        second_mate;
        logic        group_ok;
        logic        reject;
        logic [5:0]  quality;
        logic [3:0]  word;
        logic [5:0]  bin;
        logic [15:0] position;
    } work_item_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic       valid;
        work_item_t item;
    } queue_head_t;

    typedef enum logic [1:0] {
        BK_SWEEP,
        BK_IDLE,
        BK_READ,
        BK_EXEC
    } back_state_t;

endpackage

// ===== rtl/core/rqht_front.sv =====
// ----------------------------------------------------------------------------
// rqht_front
// Accepts input transfers, checks ranges and queues classified items.
// ----------------------------------------------------------------------------
module rqht_front
    import rqht_pkg::*;
#(
    parameter int NUM_GROUPS    = 16,
    parameter int NUM_QUALITIES = 64,
    parameter int NUM_LENGTHS   = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output queue_head_t head,
    input  logic        pop
);

    work_item_t  cls;
    logic        group_ok;
    logic        qual_ok;
    logic        len_ok;
    logic        push;

    work_item_t  q_mem_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    // Range checks
    assign group_ok = 9'(s_item.read_group) < 9'(NUM_GROUPS);
    assign qual_ok  = 7'(s_item.quality) < 7'(NUM_QUALITIES);
    assign len_ok   = 13'(s_item.fragment_length) < 13'(NUM_LENGTHS);

    always_comb begin
        cls.cmd         = s_item.cmd;
        cls.read_group  = s_item.read_group;
        cls.second_mate = s_item.second_mate;
        cls.group_ok    = group_ok;
        cls.reject      = !(group_ok && qual_ok && len_ok);
        cls.quality     = s_item.quality;
        cls.word        = s_item.fragment_length[9:6];
        cls.bin         = s_item.fragment_length[5:0];
        cls.position    = s_item.position;
    end

    // Two-entry queue
    assign s_ready    = (count_reg != 2'd2);
    assign push       = s_valid && s_ready;
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== rtl/core/rqht_back.sv =====
// ----------------------------------------------------------------------------
// rqht_back
// Table storage and the sequencer that carries out adds, clears and reports.
// Bins only ever count up and saturate, so a bin is nonzero exactly when it
// has been hit since the last clear; the tables keep that as used bits.
// ----------------------------------------------------------------------------
module rqht_back
    import rqht_pkg::*;
#(
    parameter int NUM_GROUPS    = 16,
    parameter int NUM_QUALITIES = 64,
    parameter int NUM_LENGTHS   = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  queue_head_t head,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item
);

    localparam int NT     = 2 * NUM_GROUPS;
    localparam int TW     = $clog2(NT);
    localparam int LW_RAW = (NUM_LENGTHS + 63) / 64;
    localparam int LW     = (LW_RAW > 16) ? 16 : LW_RAW;
    localparam int LD     = NT * LW;
    localparam int LAW    = $clog2(LD);
    localparam int IW     = 32 + 16 + NUM_QUALITIES;

    // Per table: count, max position, used-quality mask
    logic [IW-1:0] info_mem [NT];
    // Per table and 64-bin word: used-length mask
    logic [63:0]   lmask_mem [LD];

    back_state_t   state_reg, state_next;
    work_item_t    cur_reg;
    logic          cur_load;
    logic [3:0]    k_reg, k_next;
    logic [LAW-1:0] sweep_reg, sweep_next;
    logic [IW-1:0] info_rd_reg;
    logic [63:0]   lmask_rd_reg;
    logic          rd_en;

    logic          info_we;
    logic [TW-1:0] info_waddr;
    logic [IW-1:0] info_wdata;
    logic          lm_we;
    logic [LAW-1:0] lm_waddr;
    logic [63:0]   lm_wdata;

    logic          m_valid_reg;
    out_item_t     m_item_reg;
    logic          out_load;
    out_item_t     out_next;
    logic          out_free;

    logic [8:0]    t_wide;
    logic [TW-1:0] cur_t;
    logic [3:0]    cur_k;
    logic [LAW-1:0] lm_addr;

    logic [31:0]   rd_cnt, new_cnt;
    logic [15:0]   rd_max, new_max;
    logic [NUM_QUALITIES-1:0] rd_qmask, new_qmask;

    // Table and word addressing
    assign t_wide  = 9'({cur_reg.read_group, cur_reg.second_mate});
    assign cur_t   = cur_reg.group_ok ? t_wide[TW-1:0] : '0;
    assign cur_k   = (cur_reg.cmd == CMD_LREP) ? k_reg :
                     (cur_reg.reject ? 4'd0 : cur_reg.word);
    assign lm_addr = LAW'(32'(cur_t) * LW + 32'(cur_k));

    // Fields of the table entry just read
    assign rd_qmask = info_rd_reg[NUM_QUALITIES-1:0];
    assign rd_max   = info_rd_reg[NUM_QUALITIES+15:NUM_QUALITIES];
    assign rd_cnt   = info_rd_reg[IW-1:NUM_QUALITIES+16];

    // Updated entry for an add
    always_comb begin
        new_cnt   = (rd_cnt == 32'hFFFF_FFFF) ? rd_cnt : rd_cnt + 32'd1;
        new_max   = (cur_reg.position > rd_max) ? cur_reg.position : rd_max;
        new_qmask = rd_qmask | (NUM_QUALITIES'(1) << cur_reg.quality);
    end

    assign out_free = !m_valid_reg || m_ready;

    // Sequencer: next state and datapath controls
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        sweep_next = sweep_reg;
        pop        = 1'b0;
        cur_load   = 1'b0;
        rd_en      = 1'b0;
        info_we    = 1'b0;
        info_waddr = cur_t;
        info_wdata = {new_cnt, new_max, new_qmask};
        lm_we      = 1'b0;
        lm_waddr   = lm_addr;
        lm_wdata   = lmask_rd_reg | (64'd1 << cur_reg.bin);
        out_load   = 1'b0;
        out_next   = '0;
        out_next.total_count  = cur_reg.group_ok ? rd_cnt : 32'd0;
        out_next.max_position = cur_reg.group_ok ? rd_max : 16'd0;
        out_next.last         = 1'b1;
        case (state_reg)
            BK_SWEEP: begin
                // Zero one length-store entry per cycle, and one info-store entry while the index is below NT
                lm_we      = 1'b1;
                lm_waddr   = sweep_reg;
                lm_wdata   = '0;
                info_we    = (33'(sweep_reg) < 33'(NT));
                info_waddr = sweep_reg[TW-1:0];
                info_wdata = '0;
                sweep_next = sweep_reg + LAW'(1);
                if (sweep_reg == LAW'(LD - 1)) begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (head.valid) begin
                    pop        = 1'b1;
                    cur_load   = 1'b1;
                    k_next     = 4'd0;
                    state_next = BK_READ;
                end
            end
            BK_READ: begin
                rd_en      = 1'b1;
                state_next = BK_EXEC;
            end
            BK_EXEC: begin
                if (out_free) begin
                    out_load = 1'b1;
                    case (cur_reg.cmd)
                        CMD_ADD: begin
                            out_next.kind = KIND_ADD_ACK;
                            if (cur_reg.reject) begin
                                out_next.error = 1'b1;
                            end else begin
                                info_we               = 1'b1;
                                lm_we                 = 1'b1;
                                out_next.total_count  = new_cnt;
                                out_next.max_position = new_max;
                            end
                            state_next = BK_IDLE;
                        end
                        CMD_CLEAR: begin
                            out_next              = '0;
                            out_next.kind         = KIND_CLEAR_ACK;
                            out_next.last         = 1'b1;
                            sweep_next            = '0;
                            state_next            = BK_SWEEP;
                        end
                        CMD_QREP: begin
                            out_next.kind      = KIND_QREP;
                            out_next.used_mask = cur_reg.group_ok ? 64'(rd_qmask) : 64'd0;
                            state_next         = BK_IDLE;
                        end
                        default: begin
                            out_next.kind       = KIND_LWORD;
                            out_next.used_mask  = cur_reg.group_ok ? lmask_rd_reg : 64'd0;
                            out_next.word_index = k_reg;
                            out_next.last       = (k_reg == 4'(LW - 1));
                            if (k_reg == 4'(LW - 1)) begin
                                state_next = BK_IDLE;
                            end else begin
                                k_next     = k_reg + 4'd1;
                                state_next = BK_READ;
                            end
                        end
                    endcase
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_SWEEP;
            sweep_reg   <= '0;
            k_reg       <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            k_reg     <= k_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cur_load) begin
            cur_reg <= head.item;
        end
        if (out_load) begin
            m_item_reg <= out_next;
        end
    end

    // Table info store
    always_ff @(posedge aclk) begin
        if (info_we) begin
            info_mem[info_waddr] <= info_wdata;
        end
        if (rd_en) begin
            info_rd_reg <= info_mem[cur_t];
        end
    end

    // Length mask store
    always_ff @(posedge aclk) begin
        if (lm_we) begin
            lmask_mem[lm_waddr] <= lm_wdata;
        end
        if (rd_en) begin
            lmask_rd_reg <= lmask_mem[lm_addr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ===== rtl/core/read_quality_histogram_tables.sv =====
// Flow: each item leaves the queue in IDLE, its table entry is read in READ and its result is
// registered in EXEC once the output register is free; no new item is taken before that. A fragment
// report passes through READ and EXEC again for each of its W mask words, one word per pass.
// Clear and reset run a zeroing pass over all 2*NUM_GROUPS*W entries of the length store;
// up to two items are taken into the queue meanwhile. Reset: aresetn, synchronous, low.
// ----------------------------------------------------------------------------
// read_quality_histogram_tables
// Per read group and mate tables of quality and fragment-length usage.
// ----------------------------------------------------------------------------
module read_quality_histogram_tables
    import rqht_pkg::*;
#(
    parameter int NUM_GROUPS    = 16,
    parameter int NUM_QUALITIES = 64,
    parameter int NUM_LENGTHS   = 1024
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    queue_head_t head;
    logic        pop;

    // Accept and classify
    rqht_front #(
        .NUM_GROUPS    (NUM_GROUPS),
        .NUM_QUALITIES (NUM_QUALITIES),
        .NUM_LENGTHS   (NUM_LENGTHS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .head    (head),
        .pop     (pop)
    );

    // Table update and reporting
    rqht_back #(
        .NUM_GROUPS    (NUM_GROUPS),
        .NUM_QUALITIES (NUM_QUALITIES),
        .NUM_LENGTHS   (NUM_LENGTHS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule
